FILE: rtl/core/bitboard_neighborhood_dilation_assert.svh
// Assertion macros for the neighborhood dilation block.
`ifndef BITBOARD_NEIGHBORHOOD_DILATION_ASSERT_SVH
`define BITBOARD_NEIGHBORHOOD_DILATION_ASSERT_SVH
`ifndef SYNTHESIS
`define BND_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BND_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define BND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/bnd_pkg.sv
// Types, constants and the structuring-element helper of the dilation block.
package bnd_pkg;

    localparam int ROW_BITS   = 32;
    localparam int ELEM_ROWS  = 7;
    localparam int DELAY_ROWS = 4;
    // Half size of the 7x7 element: column center and row lag of the window.
    localparam int ELEM_REACH = 3;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int ROWCNT_W   = 6;
    localparam int COLCNT_W   = 5;
    localparam int ROWIDX_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = 6'd15;
    localparam logic [COLCNT_W-1:0] COL_COUNT_RST = 5'd15;

    // Rows -3 .. +3 of the sparse 7x7 element, bit j is column offset j-3.
    localparam logic [6:0] ELEM_PAT [ELEM_ROWS] =
        '{7'd73, 7'd62, 7'd62, 7'd119, 7'd62, 7'd62, 7'd73};

    typedef logic [ROW_BITS-1:0] t_row;

    typedef struct packed {
        t_row legal_row;
        t_row chosen_row;
        logic board_empty;
    } t_in;

    typedef struct packed {
        t_row                move_row;
        logic [ROWIDX_W-1:0] row_index;
        logic                last_row;
    } t_out;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // OR one element row around every occupied column; bits off the edge drop.
    function automatic t_row spread(input t_row occ, input logic [6:0] pat);
        t_row acc;
        acc = '0;
        for (int j = 0; j < 7; j++) begin
            if (pat[j]) begin
                if (j >= ELEM_REACH) begin
                    acc = acc | (occ << (j - ELEM_REACH));
                end else begin
                    acc = acc | (occ >> (ELEM_REACH - j));
                end
            end
        end
        return acc;
    endfunction

endpackage

FILE: rtl/core/bnd_nb_cell.sv
// One row of the neighborhood window: takes its upper neighbor and ORs its element row.
module bnd_nb_cell import bnd_pkg::*; #(
    parameter logic [6:0] PAT = 7'd62
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_row      i_occ,
    input  t_row      i_nb_up,
    output t_row      o_nb
);

    t_row r_nb;
    t_row n_nb;

    always_comb begin
        n_nb = r_nb;
        if (i_ctl.clear) begin
            n_nb = '0;
        end else if (i_ctl.shift) begin
            n_nb = i_nb_up | spread(i_occ, PAT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb <= '0;
        end else begin
            r_nb <= n_nb;
        end
    end

    assign o_nb = r_nb;

endmodule

FILE: rtl/core/bnd_mask_cell.sv
// One stage of the legal and chosen mask delay line.
module bnd_mask_cell import bnd_pkg::*; (
    input  logic i_clk,
    input  logic i_shift,
    input  t_row i_legal_up,
    input  t_row i_chosen_up,
    output t_row o_legal,
    output t_row o_chosen
);

    t_row r_legal;
    t_row r_chosen;

    // Advance on every window shift.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_legal  <= i_legal_up;
            r_chosen <= i_chosen_up;
        end
    end

    assign o_legal  = r_legal;
    assign o_chosen = r_chosen;

endmodule

FILE: rtl/core/bitboard_neighborhood_dilation.sv
// Top level of the row-streamed 7x7 sparse neighborhood dilation.
//
// Use: send board rows 0 .. row_count-1 on the input channel, one beat per row,
// each with its legal mask, chosen mask and the board-empty flag. The output
// channel returns one beat per board row: the candidate mask (neighborhood AND
// legal AND NOT chosen), its row index and a last-row flag on the final row.
// Row r leaves once row r+3 has arrived; the last row of the board flushes
// the rows still held.
// Path: after the edge that accepts row r+3, the beat for row r goes from the
// window register into the output register, where it becomes valid.
// Throughput: one row per cycle inside a board unless the output stalls.
// After the last row the window drains its four held rows one by one, during
// which the input is not ready.
// Stall: a result waiting in the output register does not block the input;
// when the output register is full and the next result is pending in the
// window, the input waits until the receiver takes the beat.
// Reset: row_count and col_count return to 15, the window, counter and empty
// flag clear. The configuration port is always ready; write it between boards.
module bitboard_neighborhood_dilation import bnd_pkg::*; #(
    parameter int MAX_ROWS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "bitboard_neighborhood_dilation_assert.svh"

    localparam int CW = $clog2(MAX_ROWS);
    localparam logic [1:0] FLUSH_LAST = 2'(DELAY_ROWS - 1);
    localparam logic [CNT_W-1:0] OFFSET_C = CNT_W'(ELEM_REACH);

    // Configuration registers.
    logic [ROWCNT_W-1:0] r_row_count;
    logic [COLCNT_W-1:0] r_col_count;

    // Board sequencing.
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_empty, n_empty;
    logic             r_flush, n_flush;
    logic [1:0]       r_fpos, n_fpos;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_pend_row, n_pend_row;
    logic             r_pend_last, n_pend_last;

    // Output register.
    logic r_out_v, n_out_v;
    t_out r_out, n_out;

    logic             accept, load, adv_flush, is_last;
    logic [CNT_W-1:0] k_ext, rows_raw, rows_eff, fl_pos;
    t_row             col_mask, occ, centre, result;
    t_cell_ctl        ctl;

    t_row nb_q     [ELEM_ROWS];
    t_row legal_q  [DELAY_ROWS];
    t_row chosen_q [DELAY_ROWS];

    //--------------------------------------------------------------------
    // Configuration writes
    //--------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ROW_COUNT: r_row_count <= i_cfg_data[ROWCNT_W-1:0];
                REG_COL_COUNT: r_col_count <= i_cfg_data[COLCNT_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Effective row count: zero acts as one, saturate at MAX_ROWS.
    assign rows_raw = CNT_W'(r_row_count);
    always_comb begin
        if (rows_raw == '0) begin
            rows_eff = CNT_W'(1);
        end else if (rows_raw > CNT_W'(MAX_ROWS)) begin
            rows_eff = CNT_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_raw;
        end
    end

    // Columns in use never exceed the row width, so no saturation is needed.
    assign col_mask = ~(t_row'('1) << r_col_count);
    assign occ      = accept ? (~i_in.legal_row & col_mask) : '0;

    //--------------------------------------------------------------------
    // Handshake and window control
    //--------------------------------------------------------------------
    assign load       = r_pend && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_flush && (!r_pend || load);
    assign accept     = i_in_valid && o_in_ready;
    assign adv_flush  = r_flush && (!r_pend || load);

    assign k_ext   = CNT_W'(r_cnt);
    assign is_last = (k_ext + CNT_W'(1)) >= rows_eff;
    // Row position (plus offset) of the slot that moves to the bottom next.
    assign fl_pos  = k_ext + CNT_W'(r_fpos) + CNT_W'(1);

    // Shift on every accepted row and on each drain step but the final one,
    // which clears the window as the last held row goes out.
    assign ctl.shift = accept || (adv_flush && (r_fpos != FLUSH_LAST));
    assign ctl.clear = adv_flush && (r_fpos == FLUSH_LAST);

    //--------------------------------------------------------------------
    // Cell chain: seven window rows, four mask delay stages
    //--------------------------------------------------------------------
    for (genvar g = 0; g < ELEM_ROWS; g++) begin : g_nb
        if (g == ELEM_ROWS - 1) begin : g_top
            bnd_nb_cell #(.PAT(ELEM_PAT[g])) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_occ   (occ),
                .i_nb_up ('0),
                .o_nb    (nb_q[g])
            );
        end else begin : g_mid
            bnd_nb_cell #(.PAT(ELEM_PAT[g])) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_occ   (occ),
                .i_nb_up (nb_q[g+1]),
                .o_nb    (nb_q[g])
            );
        end
    end

    for (genvar g = 0; g < DELAY_ROWS; g++) begin : g_mask
        if (g == DELAY_ROWS - 1) begin : g_top
            bnd_mask_cell u_cell (
                .i_clk       (i_clk),
                .i_shift     (ctl.shift),
                .i_legal_up  (i_in.legal_row),
                .i_chosen_up (i_in.chosen_row),
                .o_legal     (legal_q[g]),
                .o_chosen    (chosen_q[g])
            );
        end else begin : g_mid
            bnd_mask_cell u_cell (
                .i_clk       (i_clk),
                .i_shift     (ctl.shift),
                .i_legal_up  (legal_q[g+1]),
                .i_chosen_up (chosen_q[g+1]),
                .o_legal     (legal_q[g]),
                .o_chosen    (chosen_q[g])
            );
        end
    end

    //--------------------------------------------------------------------
    // Result of the bottom window row
    //--------------------------------------------------------------------
    // Empty board: mark the centre cell when the centre row goes out.
    always_comb begin
        centre = '0;
        if (r_empty && (r_pend_row == (rows_eff >> 1)) && (r_col_count != '0)) begin
            centre = t_row'(1) << (r_col_count >> 1);
        end
    end

    assign result = (nb_q[0] | centre) & legal_q[0] & ~chosen_q[0] & col_mask;

    //--------------------------------------------------------------------
    // Sequencer
    //--------------------------------------------------------------------
    always_comb begin
        n_cnt       = r_cnt;
        n_empty     = r_empty;
        n_flush     = r_flush;
        n_fpos      = r_fpos;
        n_pend      = r_pend;
        n_pend_row  = r_pend_row;
        n_pend_last = r_pend_last;

        if (accept) begin
            n_empty     = r_empty | i_in.board_empty;
            // Row k-3 sits at the bottom of the window after this shift.
            n_pend      = k_ext >= OFFSET_C;
            n_pend_row  = k_ext - OFFSET_C;
            n_pend_last = 1'b0;
            if (is_last) begin
                n_flush = 1'b1;
                n_fpos  = '0;
            end else begin
                n_cnt = r_cnt + CW'(1);
            end
        end else if (adv_flush) begin
            if (r_fpos == FLUSH_LAST) begin
                // Board done: return to the reset state.
                n_flush = 1'b0;
                n_fpos  = '0;
                n_pend  = 1'b0;
                n_cnt   = '0;
                n_empty = 1'b0;
            end else begin
                n_fpos      = r_fpos + 2'd1;
                n_pend      = fl_pos >= OFFSET_C;
                n_pend_row  = fl_pos - OFFSET_C;
                n_pend_last = (r_fpos + 2'd1) == FLUSH_LAST;
            end
        end else if (load) begin
            n_pend = 1'b0;
        end
    end

    always_comb begin
        n_out_v = r_out_v;
        n_out   = r_out;
        if (load) begin
            n_out_v         = 1'b1;
            n_out.move_row  = result;
            n_out.row_index = r_pend_row[ROWIDX_W-1:0];
            n_out.last_row  = r_pend_last;
        end else if (i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_empty     <= 1'b0;
            r_flush     <= 1'b0;
            r_fpos      <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_empty     <= n_empty;
            r_flush     <= n_flush;
            r_fpos      <= n_fpos;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_out_v     <= n_out_v;
        end
    end

    // Payload: hold the pending row index and the output beat, no reset.
    always_ff @(posedge i_clk) begin
        r_pend_row <= n_pend_row;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    `BND_ASSERT_NEXT(a_clear_resets_board, i_clk, i_rst_n, ctl.clear, (r_cnt == '0) && !r_empty && !r_flush, "board state not cleared after flush")
    `BND_ASSERT_NOW(a_last_only_at_flush_end, i_clk, i_rst_n, load && r_pend_last, r_flush && (r_fpos == FLUSH_LAST), "last row sent outside the end of a flush")
    `BND_ASSERT_NEXT(a_count_steps_by_one, i_clk, i_rst_n, accept && !is_last, r_cnt == ($past(r_cnt) + CW'(1)), "row counter did not advance by one")

endmodule

FILE: sim/bitboard_neighborhood_dilation_test.sv
// Self-checking testbench of the row-streamed 7x7 sparse neighborhood dilation.
`timescale 1ns / 1ps

module bitboard_neighborhood_dilation_test;
    import bnd_pkg::*;

    localparam int BOARD_MAX_ROWS = 32;
    localparam int RANDOM_ITEMS   = 380;
    localparam int PHASE_ITEMS    = 50;
    // Worst case after the newest row: the path to the output register plus
    // a four-row drain, with margin.
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RST_CYCLES     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
    localparam logic [ROWCNT_W-1:0]  RST_ROWS     = 6'd15;
    localparam logic [COLCNT_W-1:0]  RST_COLS     = 5'd15;

    // Element rows for offsets -3 .. +3, bit j is column offset j-3.
    localparam logic [6:0] SPARSE_ELEM [7] = '{7'd73, 7'd62, 7'd62, 7'd119,
                                               7'd62, 7'd62, 7'd73};

    typedef enum {OP_ROW, OP_CFG, OP_DRAIN, OP_MODE} t_op_kind;

    // One entry of the stimulus script: a row beat, a register write, a wait
    // for the block to go quiet, or a change of idle rates.
    typedef struct {
        t_op_kind              kind;
        t_in                   beat;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int                    gap_pct;
        int                    stall_pct;
    } t_board_op;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in        = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out                  o_out;
    logic                  o_cfg_ready;

    always #1 i_clk = ~i_clk;

    bitboard_neighborhood_dilation #(
        .MAX_ROWS(BOARD_MAX_ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Dilation predictor: its own copy of the window, delay lines and
    // registers, advanced once per accepted row beat.
    // ------------------------------------------------------------------
    t_row                 hood_win    [7];
    t_row                 legal_hist  [4];
    t_row                 chosen_hist [4];
    int                   next_row    = 0;
    bit                   empty_seen  = 1'b0;
    logic [ROWCNT_W-1:0]  cfg_rows    = RST_ROWS;
    logic [COLCNT_W-1:0]  cfg_cols    = RST_COLS;
    t_out                 expected_moves [$];

    int                   fail_count    = 0;
    int                   settle_cycles = 0;
    int                   idle_run      = 0;
    logic                 in_fire       = 1'b0;
    logic                 cfg_fire      = 1'b0;

    // Zero rows act as one; anything past the board height saturates.
    function automatic int rows_in_use(logic [ROWCNT_W-1:0] r);
        if (r == 0) return 1;
        if (r > BOARD_MAX_ROWS) return BOARD_MAX_ROWS;
        return int'(r);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < 7; i++) hood_win[i] = '0;
        for (int i = 0; i < 4; i++) begin
            legal_hist[i]  = '0;
            chosen_hist[i] = '0;
        end
        next_row   = 0;
        empty_seen = 1'b0;
    endfunction

    // Candidate cells of the row held in one delay slot.
    function automatic t_out move_beat(int slot, int row, bit fin, int n_rows, int n_cols);
        t_out res;
        t_row nb;
        t_row cmask;
        cmask = t_row'((64'd1 << n_cols) - 64'd1);
        nb    = hood_win[slot];
        // Mark the center on an empty board; with no columns there is none.
        if (empty_seen && row == n_rows / 2 && n_cols > 0)
            nb = nb | (t_row'(1) << (n_cols / 2));
        res.move_row  = nb & legal_hist[slot] & ~chosen_hist[slot] & cmask;
        res.row_index = row[ROWIDX_W-1:0];
        res.last_row  = fin;
        return res;
    endfunction

    task automatic predict_moves(input t_in beat);
        int          n_rows;
        int          n_cols;
        int          k;
        t_row        occ;
        logic [38:0] wide;
        n_rows = rows_in_use(cfg_rows);
        // col_count is five bits wide, so it never exceeds the row width.
        n_cols = int'(cfg_cols);
        k      = next_row;
        if (beat.board_empty) empty_seen = 1'b1;

        // Advance the window and the delay lines by one row.
        for (int i = 0; i < 6; i++) hood_win[i] = hood_win[i + 1];
        hood_win[6] = '0;
        for (int i = 0; i < 3; i++) begin
            legal_hist[i]  = legal_hist[i + 1];
            chosen_hist[i] = chosen_hist[i + 1];
        end
        legal_hist[3]  = beat.legal_row;
        chosen_hist[3] = beat.chosen_row;

        // Stamp the element around every occupied column in use; a shift by
        // c then dropping three bits centers offset zero on column c.
        occ = ~beat.legal_row & t_row'((64'd1 << n_cols) - 64'd1);
        for (int c = 0; c < n_cols; c++) begin
            if (occ[c]) begin
                for (int i = 0; i < 7; i++) begin
                    wide        = {32'b0, SPARSE_ELEM[i]} << c;
                    hood_win[i] = hood_win[i] | wide[34:3];
                end
            end
        end

        if (k + 1 < n_rows) begin
            if (k >= ELEM_REACH)
                expected_moves.push_back(move_beat(0, k - ELEM_REACH, 1'b0, n_rows, n_cols));
            next_row = k + 1;
        end else begin
            // Last row, or a counter already past it: flush every held row.
            for (int i = 0; i < 4; i++) begin
                if (k + i >= ELEM_REACH)
                    expected_moves.push_back(
                        move_beat(i, k + i - ELEM_REACH, i == 3, n_rows, n_cols));
            end
            clear_window();
        end
    endtask

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ROW_COUNT: begin
                cfg_rows = data[ROWCNT_W-1:0];
            end
            REG_COL_COUNT: begin
                cfg_cols = data[COLCNT_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge, predict on each
    // accepted row beat, check each accepted result beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_beats
        t_out want;
        in_fire  <= i_rst_n && i_in_valid && o_in_ready;
        cfg_fire <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) predict_moves(i_in);
            if (o_out_valid && i_out_ready) begin
                if (expected_moves.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual move_row %h row %0d",
                             $time, o_out.move_row, o_out.row_index);
                    fail_count++;
                end else begin
                    want = expected_moves.pop_front();
                    check_field("move_row", want.move_row, o_out.move_row);
                    check_field("row_index", 32'(want.row_index), 32'(o_out.row_index));
                    check_field("last_row", 32'(want.last_row), 32'(o_out.last_row));
                end
            end
            // Count quiet cycles: no row taken and nothing still owed.
            if ((i_in_valid && o_in_ready) || expected_moves.size() != 0)
                settle_cycles = 0;
            else if (settle_cycles < SETTLE_CYCLES)
                settle_cycles++;
        end
    end

    // Watchdog: give up when no channel moves a beat for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("[bitboard_neighborhood_dilation] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: walk the script at the falling edge; hold each beat until it
    // is taken, wait for a quiet block before any register write.
    // ------------------------------------------------------------------
    t_board_op board_script [$];
    int        send_gap_pct = 0;
    int        stall_pct    = 0;

    always @(negedge i_clk) begin : drive_beats
        logic                  nxt_valid;
        t_in                   nxt_beat;
        logic                  nxt_cfg_valid;
        logic [CFG_IDX_W-1:0]  nxt_idx;
        logic [CFG_DATA_W-1:0] nxt_data;
        t_board_op             op;
        bit                    quiet;
        nxt_valid     = i_in_valid && !in_fire;
        nxt_beat      = i_in;
        nxt_cfg_valid = i_cfg_valid && !cfg_fire;
        nxt_idx       = i_cfg_index;
        nxt_data      = i_cfg_data;
        quiet         = expected_moves.size() == 0 && settle_cycles >= SETTLE_CYCLES;
        if (i_rst_n && !nxt_valid && !nxt_cfg_valid && board_script.size() > 0) begin
            case (board_script[0].kind)
                OP_ROW: begin
                    if ($urandom_range(99) >= send_gap_pct) begin
                        op        = board_script.pop_front();
                        nxt_valid = 1'b1;
                        nxt_beat  = op.beat;
                    end
                end
                OP_CFG: begin
                    if (quiet) begin
                        op            = board_script.pop_front();
                        nxt_cfg_valid = 1'b1;
                        nxt_idx       = op.idx;
                        nxt_data      = op.data;
                    end
                end
                OP_DRAIN: begin
                    if (quiet) op = board_script.pop_front();
                end
                default: begin
                    op           = board_script.pop_front();
                    send_gap_pct = op.gap_pct;
                    stall_pct    = op.stall_pct;
                end
            endcase
        end
        i_in_valid  <= nxt_valid;
        i_in        <= nxt_beat;
        i_cfg_valid <= nxt_cfg_valid;
        i_cfg_index <= nxt_idx;
        i_cfg_data  <= nxt_data;
        i_out_ready <= $urandom_range(99) >= stall_pct;
    end

    // ------------------------------------------------------------------
    // Script building
    // ------------------------------------------------------------------
    int                  row_beats = 0;
    logic [ROWCNT_W-1:0] gen_rows  = RST_ROWS;

    task automatic add_row(input t_row legal, input t_row chosen, input logic empty);
        t_board_op op;
        op.kind             = OP_ROW;
        op.beat.legal_row   = legal;
        op.beat.chosen_row  = chosen;
        op.beat.board_empty = empty;
        board_script.push_back(op);
        row_beats++;
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        t_board_op op;
        op.kind = OP_CFG;
        op.idx  = idx;
        op.data = data;
        board_script.push_back(op);
        // Track the board height so generated boards line up with the flush.
        if (idx == REG_ROW_COUNT) gen_rows = data[ROWCNT_W-1:0];
    endtask

    task automatic add_drain();
        t_board_op op;
        op.kind = OP_DRAIN;
        board_script.push_back(op);
    endtask

    task automatic add_mode(input int gap, input int stall);
        t_board_op op;
        op.kind      = OP_MODE;
        op.gap_pct   = gap;
        op.stall_pct = stall;
        board_script.push_back(op);
    endtask

    // A board row with a random mix of stones, chosen moves and flags.
    task automatic add_rand_row();
        t_row legal;
        t_row chosen;
        case ($urandom_range(3))
            0: legal = $urandom();
            1, 2: legal = $urandom() | $urandom() | $urandom();
            default: legal = ~(t_row'(1) << $urandom_range(31));
        endcase
        case ($urandom_range(2))
            0: chosen = '0;
            1: chosen = $urandom() & $urandom();
            default: chosen = $urandom();
        endcase
        add_row(legal, chosen, $urandom_range(19) == 0);
    endtask

    task automatic add_rand_config();
        case ($urandom_range(19))
            0: add_cfg(REG_ROW_COUNT, 6'd0);
            1: add_cfg(REG_ROW_COUNT, 6'd1);
            2: add_cfg(REG_ROW_COUNT, 6'd2);
            3: add_cfg(REG_ROW_COUNT, 6'd3);
            4: add_cfg(REG_ROW_COUNT, 6'd32);
            5: add_cfg(REG_ROW_COUNT, 6'd63);
            default: add_cfg(REG_ROW_COUNT, CFG_DATA_W'($urandom_range(4, 12)));
        endcase
        // Bit 5 of the column write is outside the register; toggle it anyway.
        case ($urandom_range(5))
            0: add_cfg(REG_COL_COUNT, {1'($urandom_range(1)), 5'd0});
            1: add_cfg(REG_COL_COUNT, {1'($urandom_range(1)), 5'd31});
            2: add_cfg(REG_COL_COUNT, {1'($urandom_range(1)), 5'd1});
            default: add_cfg(REG_COL_COUNT, {1'($urandom_range(1)), 5'($urandom_range(3, 31))});
        endcase
        if ($urandom_range(7) == 0)
            add_cfg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_DATA_W'($urandom()));
    endtask

    initial begin : run_boards
        int n;
        int m;
        int j;
        int phase;
        int last_phase;
        int base;

        // Directed: single-row board with no columns in use.
        add_cfg(REG_ROW_COUNT, 6'd0);
        add_cfg(REG_COL_COUNT, 6'd0);
        add_row('0, '0, 1'b1);

        // Widest board, field extremes, fully occupied row.
        add_cfg(REG_ROW_COUNT, 6'd4);
        add_cfg(REG_COL_COUNT, 6'h3F);
        add_row('1, '0, 1'b1);
        add_row('0, '1, 1'b0);
        add_row('1, '0, 1'b0);
        add_row(32'hAAAAAAAA, 32'h55555555, 1'b0);

        // Ignored indexes, then stones on the left and right edges.
        add_cfg(REG_UNUSED_2, 6'h3F);
        add_cfg(REG_UNUSED_3, 6'h15);
        add_cfg(REG_ROW_COUNT, 6'd5);
        add_cfg(REG_COL_COUNT, 6'd7);
        add_row(~t_row'(1), '0, 1'b0);
        add_row('1, '0, 1'b0);
        add_row(~(t_row'(1) << 6), '0, 1'b0);
        add_row(~(t_row'(1) << 3), 32'h0000_0041, 1'b0);
        add_row('1, $urandom(), 1'b0);

        // Shrink the board mid-way so the counter runs past the last row.
        add_cfg(REG_ROW_COUNT, 6'd15);
        add_cfg(REG_COL_COUNT, 6'd15);
        repeat (6) add_rand_row();
        add_cfg(REG_ROW_COUNT, 6'd3);
        add_rand_row();

        // Board shorter than the window depth.
        add_cfg(REG_ROW_COUNT, 6'd2);
        add_cfg(REG_COL_COUNT, 6'd29);
        repeat (2) add_rand_row();

        // Empty board: the flag on a later row still marks the center.
        add_cfg(REG_ROW_COUNT, 6'd3);
        add_row('1, '0, 1'b0);
        add_row('1, '0, 1'b1);
        add_row('1, '0, 1'b0);

        // Random boards, rotating the idle rates every few dozen rows.
        base       = row_beats;
        last_phase = -1;
        while (row_beats < base + RANDOM_ITEMS) begin
            phase = ((row_beats - base) / PHASE_ITEMS) % 4;
            if (phase != last_phase) begin
                case (phase)
                    0: add_mode(0, 0);
                    1: add_mode(49, 0);
                    2: add_mode(0, 49);
                    default: add_mode(19, 19);
                endcase
                last_phase = phase;
            end
            if ($urandom_range(3) == 0) add_rand_config();
            n = rows_in_use(gen_rows);
            case ($urandom_range(9))
                0: begin
                    if (n > 1) begin
                        // Cut the board short, then shrink it so the next row flushes.
                        m = $urandom_range(1, n - 1);
                        repeat (m) add_rand_row();
                        add_cfg(REG_ROW_COUNT, CFG_DATA_W'($urandom_range(0, m + 1)));
                    end
                    add_rand_row();
                end
                1: begin
                    j = $urandom_range(n - 1);
                    for (int r = 0; r < n; r++)
                        add_row('1, $urandom() & $urandom(), r == j);
                end
                default: begin
                    repeat (n) add_rand_row();
                end
            endcase
            // Hold the sender until every result is back.
            if ($urandom_range(7) == 0) add_drain();
        end

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (board_script.size() != 0 || i_in_valid || expected_moves.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("[bitboard_neighborhood_dilation] OK");
        else
            $display("[bitboard_neighborhood_dilation] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bnd_pkg.sv
rtl/core/bnd_nb_cell.sv
rtl/core/bnd_mask_cell.sv
rtl/core/bitboard_neighborhood_dilation.sv
sim/bitboard_neighborhood_dilation_test.sv
